// File: hw/rtl/ccr_pkg.sv
`timescale 1ns / 1ps

package ccr_pkg;

  // Default number format: Q20.12 in a 32-bit word.
  localparam int unsigned WordBitsDef     = 32;
  localparam int unsigned FractionBitsDef = 12;

  // Field widths on the streaming ports.
  localparam int unsigned PosW = 32;
  localparam int unsigned RadW = 31;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = 192;
  localparam int unsigned OutDataW = 72;

endpackage

// File: hw/rtl/ccr_sqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root of (s << F), one result bit per stage.
// A negative s gives a root of zero. Side data travels alongside.
module ccr_sqrt #(
  parameter int unsigned W  = ccr_pkg::WordBitsDef,
  parameter int unsigned F  = ccr_pkg::FractionBitsDef,
  parameter int unsigned SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [W-1:0] s_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [W-1:0]        root_o,
  output logic [SW-1:0]       side_o
);

  localparam int unsigned RB = (W + F + 1) / 2;
  localparam int unsigned NB = 2 * RB;
  localparam int unsigned RW = RB + 3;

  logic [NB-1:0] n0;
  logic          v_q    [RB];
  logic [RW-1:0] rem_q  [RB];
  logic [RB-1:0] root_q [RB];
  logic [NB-1:0] n_q    [RB];
  logic [SW-1:0] side_q [RB];

  // Radicand scaled by the fraction bits; negative values clamp to zero.
  assign n0 = s_i[W-1] ? '0 : (NB'($unsigned(s_i)) << F);

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic          pv;
    logic [RW-1:0] prem;
    logic [RB-1:0] proot;
    logic [NB-1:0] pn;
    logic [SW-1:0] pside;
    logic [RW-1:0] remsh;
    logic [RW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign pv    = valid_i;
      assign prem  = '0;
      assign proot = '0;
      assign pn    = n0;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = v_q[k-1];
      assign prem  = rem_q[k-1];
      assign proot = root_q[k-1];
      assign pn    = n_q[k-1];
      assign pside = side_q[k-1];
    end

    // Bring down two radicand bits and try the next root bit.
    assign remsh = {prem[RW-3:0], pn[NB-1 -: 2]};
    assign trial = RW'({proot, 2'b01});
    assign ge    = remsh >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? remsh - trial : remsh;
        root_q[k] <= {proot[RB-2:0], ge};
        n_q[k]    <= pn << 2;
        side_q[k] <= pside;
      end
    end
  end

  assign valid_o = v_q[RB-1];
  assign root_o  = W'(root_q[RB-1]);
  assign side_o  = side_q[RB-1];

endmodule

// File: hw/rtl/ccr_div.sv
`timescale 1ns / 1ps

// Two-lane pipelined restoring divider: (x << F) / d, truncated toward zero,
// both lanes sharing one divisor. One quotient bit per stage.
module ccr_div #(
  parameter int unsigned W  = ccr_pkg::WordBitsDef,
  parameter int unsigned F  = ccr_pkg::FractionBitsDef,
  parameter int unsigned SW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [W-1:0] x0_i,
  input  logic signed [W-1:0] x1_i,
  input  logic signed [W-1:0] d_i,
  input  logic [SW-1:0]       side_i,
  output logic                valid_o,
  output logic [W-1:0]        q0_o,
  output logic [W-1:0]        q1_o,
  output logic [SW-1:0]       side_o
);

  localparam int unsigned Q = W + F;

  // One restoring step: returns {remainder, shifted numerator with new bit}.
  function automatic logic [W+Q-1:0] div_step(logic [W-1:0] rem, logic [Q-1:0] num,
                                               logic [W-1:0] md);
    logic [W:0] r2;
    logic       ge;
    logic [W:0] rn;
    r2 = {rem, num[Q-1]};
    ge = r2 >= {1'b0, md};
    rn = ge ? r2 - {1'b0, md} : r2;
    return {rn[W-1:0], num[Q-2:0], ge};
  endfunction

  logic [W-1:0]  mx0, mx1, md0;
  logic          v_q    [Q];
  logic [W-1:0]  rem0_q [Q];
  logic [W-1:0]  rem1_q [Q];
  logic [Q-1:0]  num0_q [Q];
  logic [Q-1:0]  num1_q [Q];
  logic [W-1:0]  md_q   [Q];
  logic          neg0_q [Q];
  logic          neg1_q [Q];
  logic [SW-1:0] side_q [Q];

  // Magnitudes; the most negative word maps to its unsigned magnitude.
  assign mx0 = x0_i[W-1] ? W'(-x0_i) : W'(x0_i);
  assign mx1 = x1_i[W-1] ? W'(-x1_i) : W'(x1_i);
  assign md0 = d_i[W-1]  ? W'(-d_i)  : W'(d_i);

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic          pv;
    logic [W-1:0]  prem0, prem1, pmd;
    logic [Q-1:0]  pnum0, pnum1;
    logic          pneg0, pneg1;
    logic [SW-1:0] pside;

    if (k == 0) begin : g_first
      assign pv    = valid_i;
      assign prem0 = '0;
      assign prem1 = '0;
      assign pnum0 = Q'(mx0) << F;
      assign pnum1 = Q'(mx1) << F;
      assign pmd   = md0;
      assign pneg0 = x0_i[W-1] ^ d_i[W-1];
      assign pneg1 = x1_i[W-1] ^ d_i[W-1];
      assign pside = side_i;
    end else begin : g_next
      assign pv    = v_q[k-1];
      assign prem0 = rem0_q[k-1];
      assign prem1 = rem1_q[k-1];
      assign pnum0 = num0_q[k-1];
      assign pnum1 = num1_q[k-1];
      assign pmd   = md_q[k-1];
      assign pneg0 = neg0_q[k-1];
      assign pneg1 = neg1_q[k-1];
      assign pside = side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        {rem0_q[k], num0_q[k]} <= div_step(prem0, pnum0, pmd);
        {rem1_q[k], num1_q[k]} <= div_step(prem1, pnum1, pmd);
        md_q[k]   <= pmd;
        neg0_q[k] <= pneg0;
        neg1_q[k] <= pneg1;
        side_q[k] <= pside;
      end
    end
  end

  // Apply the sign and wrap to the word.
  assign valid_o = v_q[Q-1];
  assign q0_o    = neg0_q[Q-1] ? W'(-num0_q[Q-1]) : W'(num0_q[Q-1]);
  assign q1_o    = neg1_q[Q-1] ? W'(-num1_q[Q-1]) : W'(num1_q[Q-1]);
  assign side_o  = side_q[Q-1];

endmodule

// File: hw/rtl/circle_circle_collision_resolve.sv
`timescale 1ns / 1ps

// Circle-versus-circle collision test with push-apart vector.
// Input channel (s_axis): one pair of circles per transaction, centres and radii as
// fixed-point raw words. Output channel (m_axis): one result per input transaction,
// in order: the intersect flag, the push vector (x, z) and the coincident flag.
// Throughput: one transaction per cycle while the receiver does not stall; every stage
// is registered and fully pipelined. The depth grows with the word and fraction widths
// (default Q20.12) and is set by the square root, which resolves one root bit per
// stage, and the divider, which resolves one quotient bit per stage.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops in the
// same cycle; no transaction is lost or repeated. A waiting result blocks new input
// until the receiver takes it, even while earlier stages hold no data.
// Reset clears every valid bit, so the output channel is empty after reset.
module circle_circle_collision_resolve #(
  parameter int unsigned WORD_BITS     = ccr_pkg::WordBitsDef,
  parameter int unsigned FRACTION_BITS = ccr_pkg::FractionBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // a_x[31:0], a_z[63:32], a_radius[94:64], b_x[126:95], b_z[158:127], b_radius[189:159]
  input  logic [ccr_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // intersects[0], push_x[32:1], push_z[64:33], coincident[65]
  output logic [ccr_pkg::OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned SW = 3 * W + 1;
  localparam int unsigned PW = ccr_pkg::PosW;

  // Fixed-point product: exact signed product, floor shift, wrapped to the word.
  function automatic logic signed [W-1:0] fx_mul(logic signed [W-1:0] a,
                                                 logic signed [W-1:0] b);
    logic signed [2*W+F-1:0] p;
    p = (2*W+F)'(a) * (2*W+F)'(b);
    return p[F +: W];
  endfunction

  logic                en;
  logic signed [PW-1:0] in_ax, in_az, in_bx, in_bz;
  logic [PW-1:0]        in_ar, in_br;

  // Stage 1: differences and radius sum.
  logic                v1_q;
  logic signed [W-1:0] dx1_q, dz1_q, rs1_q;
  // Stage 2: products.
  logic                v2_q;
  logic signed [W-1:0] dx2_q, dz2_q, rs2_q, pdx2_q, pdz2_q, prs2_q;
  // Stage 3: squared distance and intersect compare.
  logic                v3_q, inter3_q;
  logic signed [W-1:0] dx3_q, dz3_q, rs3_q, sq3_q;
  // Square root output.
  logic                vs;
  logic [W-1:0]        root;
  logic [SW-1:0]       sside;
  // Stage 4: distance and overlap.
  logic                v4_q, inter4_q, coin4_q;
  logic signed [W-1:0] dx4_q, dz4_q, ov4_q, dist4_q;
  // Stage 5: numerators for the division.
  logic                v5_q, inter5_q, coin5_q;
  logic signed [W-1:0] nx5_q, nz5_q, dist5_q;
  // Divider output.
  logic                vd;
  logic [W-1:0]        qx, qz;
  logic [1:0]          dside;
  // Output register.
  logic                vo_q, inter_o_q, coin_o_q;
  logic signed [W-1:0] px_o_q, pz_o_q;

  // The pipeline advances whenever the output register is free or being taken.
  assign en            = !vo_q || m_axis_tready;
  assign s_axis_tready = en;

  assign in_ax = s_axis_tdata[31:0];
  assign in_az = s_axis_tdata[63:32];
  assign in_ar = PW'(s_axis_tdata[94:64]);
  assign in_bx = s_axis_tdata[126:95];
  assign in_bz = s_axis_tdata[158:127];
  assign in_br = PW'(s_axis_tdata[189:159]);

  // Valid bits of the arithmetic stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= vs;
      v5_q <= v4_q;
      vo_q <= vd;
    end
  end

  // Datapath registers of the stages around the square root and the divider.
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q    <= W'(in_ax) - W'(in_bx);
      dz1_q    <= W'(in_az) - W'(in_bz);
      rs1_q    <= W'(in_ar) + W'(in_br);

      dx2_q    <= dx1_q;
      dz2_q    <= dz1_q;
      rs2_q    <= rs1_q;
      pdx2_q   <= fx_mul(dx1_q, dx1_q);
      pdz2_q   <= fx_mul(dz1_q, dz1_q);
      prs2_q   <= fx_mul(rs1_q, rs1_q);

      dx3_q    <= dx2_q;
      dz3_q    <= dz2_q;
      rs3_q    <= rs2_q;
      sq3_q    <= pdx2_q + pdz2_q;
      inter3_q <= (pdx2_q + pdz2_q) <= prs2_q;

      dist4_q  <= root;
      coin4_q  <= root == '0;
      ov4_q    <= $signed(sside[3*W-1:2*W]) - $signed(root);
      dx4_q    <= sside[W-1:0];
      dz4_q    <= sside[2*W-1:W];
      inter4_q <= sside[3*W];

      nx5_q    <= fx_mul(ov4_q, dx4_q);
      nz5_q    <= fx_mul(ov4_q, dz4_q);
      dist5_q  <= dist4_q;
      coin5_q  <= coin4_q;
      inter5_q <= inter4_q;

      inter_o_q <= dside[1];
      coin_o_q  <= dside[0];
      px_o_q    <= dside[0] ? '0 : qx;
      pz_o_q    <= dside[0] ? '0 : qz;
    end
  end

  ccr_sqrt #(
    .W  (W),
    .F  (F),
    .SW (SW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .s_i     (sq3_q),
    .side_i  ({inter3_q, rs3_q, dz3_q, dx3_q}),
    .valid_o (vs),
    .root_o  (root),
    .side_o  (sside)
  );

  ccr_div #(
    .W  (W),
    .F  (F),
    .SW (2)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .x0_i    (nx5_q),
    .x1_i    (nz5_q),
    .d_i     (dist5_q),
    .side_i  ({inter5_q, coin5_q}),
    .valid_o (vd),
    .q0_o    (qx),
    .q1_o    (qz),
    .side_o  (dside)
  );

  // Result transaction, push components sign-extended to the port width.
  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {6'b0, coin_o_q, PW'(pz_o_q), PW'(px_o_q), inter_o_q};

`ifndef SYNTH
  // A coincident pair never carries a push vector.
  a_coin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q && coin_o_q |-> px_o_q == '0 && pz_o_q == '0)
    else $error("coincident result with nonzero push vector");

  // The input side is ready exactly when the pipeline advances.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow pipeline advance");

  // An accepted transaction reaches the second stage on the next advance.
  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && en |=> v2_q)
    else $error("valid bit lost between first and second stage");

  // A held pipeline keeps its first stage.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v1_q) && $stable(dx1_q))
    else $error("first stage changed during a stall");
`endif

endmodule
